### sv/twtq_pkg.sv
// Package for the timing wheel timer queue: payload structs, queue command
// and state machine types, and shared constants. No dependencies.
package twtq_pkg;

  localparam int unsigned DefWheelSlots = 4096;
  localparam int unsigned DefMaxTimers  = 64;
  localparam int unsigned SlotIdxW      = 16;      // holds a slot index up to 65535
  localparam logic [6:0]  EntryNil      = 7'd64;   // empty slot / end of chain
  localparam int unsigned QueueDepth    = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BEFORE   = 2'd1,
    ST_PAST     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_REPLY = 2'd0,
    OP_ADD   = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_ADD_RD,
    B_ADD_WR,
    B_TK_RD,
    B_TK_EL,
    B_TK_END
  } back_state_e;

  typedef struct packed {
    logic        kind;
    logic [5:0]  timer_id;
    logic [47:0] expire_time;
    logic [47:0] now;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       clamped;
    logic       expired_valid;
    logic [5:0] expired_id;
    logic       last;
  } result_t;

  typedef struct packed {
    op_e                 op;
    logic [1:0]          status;
    logic                clamped;
    logic                store;
    logic [5:0]          timer_id;
    logic [SlotIdxW-1:0] slot;
    logic [SlotIdxW-1:0] span_m1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### sv/twtq_queue.sv
// Two-entry command queue between the front and the back of the timer queue.
// Depends on twtq_pkg.
module twtq_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  twtq_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output twtq_pkg::cmd_t      cmd_o,
  output twtq_pkg::q_status_t status_o
);

  twtq_pkg::cmd_t mem_q [twtq_pkg::QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + 1'(push_i);
    rd_ptr_d = rd_ptr_q + 1'(pop_i);
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign cmd_o          = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'(twtq_pkg::QueueDepth));
  assign status_o.empty = (count_q == 2'd0);

endmodule

### sv/twtq_front.sv
// Front of the timer queue: accepts items, checks times, works out the slot
// and span, owns the wheel start time and index. Depends on twtq_pkg.
module twtq_front #(
  parameter int unsigned WHEEL_SLOTS = twtq_pkg::DefWheelSlots,
  parameter int unsigned MAX_TIMERS  = twtq_pkg::DefMaxTimers
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  twtq_pkg::item_t     item_i,
  input  logic                q_full_i,
  output logic                push_o,
  output twtq_pkg::cmd_t      cmd_o
);

  localparam int unsigned SW = $clog2(WHEEL_SLOTS);

  twtq_pkg::front_state_e state_q, state_d;
  twtq_pkg::item_t        item_q;
  logic                   started_q;
  logic [47:0]            start_time_q;
  logic [SW-1:0]          start_slot_q;
  logic                   lt_start_q, exp_past_q;
  logic [47:0]            diff_q, tdf_q;

  logic                   accept;
  logic                   big;
  logic [47:0]            sel;
  logic [SW-1:0]          off;
  logic [SW:0]            sum;
  logic [SW-1:0]          slot_wrap;
  logic [1:0]             status;

  assign accept = start_i && (state_q == twtq_pkg::F_IDLE);
  assign busy_o = (state_q != twtq_pkg::F_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      twtq_pkg::F_IDLE: if (start_i) state_d = twtq_pkg::F_CALC;
      twtq_pkg::F_CALC: state_d = twtq_pkg::F_PUSH;
      twtq_pkg::F_PUSH: if (!q_full_i) state_d = twtq_pkg::F_IDLE;
      default:          state_d = twtq_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    sel       = item_q.kind ? tdf_q : diff_q;
    big       = (sel >= 48'(WHEEL_SLOTS));
    off       = big ? SW'(WHEEL_SLOTS - 1) : sel[SW-1:0];
    sum       = {1'b0, start_slot_q} + {1'b0, off};
    slot_wrap = (sum >= (SW+1)'(WHEEL_SLOTS)) ? SW'(sum - (SW+1)'(WHEEL_SLOTS)) : sum[SW-1:0];
    if (lt_start_q) begin
      status = twtq_pkg::ST_BEFORE;
    end else if (!item_q.kind && exp_past_q) begin
      status = twtq_pkg::ST_PAST;
    end else begin
      status = twtq_pkg::ST_OK;
    end
    push_o           = (state_q == twtq_pkg::F_PUSH) && !q_full_i;
    cmd_o.status     = status;
    cmd_o.op         = (status != twtq_pkg::ST_OK) ? twtq_pkg::OP_REPLY :
                       item_q.kind ? twtq_pkg::OP_TICK : twtq_pkg::OP_ADD;
    cmd_o.clamped    = (status == twtq_pkg::ST_OK) && !item_q.kind && big;
    cmd_o.store      = ({1'b0, item_q.timer_id} < 7'(MAX_TIMERS));
    cmd_o.timer_id   = item_q.timer_id;
    cmd_o.slot       = item_q.kind ? twtq_pkg::SlotIdxW'(start_slot_q)
                                   : twtq_pkg::SlotIdxW'(slot_wrap);
    cmd_o.span_m1    = twtq_pkg::SlotIdxW'(off);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= twtq_pkg::F_IDLE;
      started_q    <= 1'b0;
      start_time_q <= 48'd0;
      start_slot_q <= '0;
    end else begin
      state_q <= state_d;
      // first operation after reset latches the wheel start
      if (accept && !started_q) begin
        started_q    <= 1'b1;
        start_time_q <= item_i.now;
        start_slot_q <= '0;
      end
      // a tick that is not before the start moves the start to now once its command is queued
      if (push_o && item_q.kind && !lt_start_q) begin
        start_time_q <= item_q.now;
        start_slot_q <= slot_wrap;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (state_q == twtq_pkg::F_CALC) begin
      lt_start_q <= (item_q.now < start_time_q);
      exp_past_q <= (item_q.expire_time < item_q.now);
      diff_q     <= item_q.expire_time - start_time_q;
      tdf_q      <= item_q.now - start_time_q;
    end
  end

endmodule

### sv/twtq_back.sv
// Back of the timer queue: slot head/tail and chain memories, pending bits,
// add and drain sequencing, result register. Depends on twtq_pkg.
module twtq_back #(
  parameter int unsigned WHEEL_SLOTS = twtq_pkg::DefWheelSlots,
  parameter int unsigned MAX_TIMERS  = twtq_pkg::DefMaxTimers
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  twtq_pkg::cmd_t      cmd_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output twtq_pkg::result_t   result_o
);

  localparam int unsigned SW = $clog2(WHEEL_SLOTS);
  localparam int unsigned IW = $clog2(MAX_TIMERS);

  logic [6:0]    head_mem [WHEEL_SLOTS];
  logic [IW-1:0] tail_mem [WHEEL_SLOTS];
  logic [6:0]    next_mem [MAX_TIMERS];

  twtq_pkg::back_state_e state_q, state_d;
  twtq_pkg::cmd_t        cur_q;
  logic [MAX_TIMERS-1:0] pending_q, pending_d;
  logic [SW-1:0]         clr_q, slot_q, rem_q;
  logic                  from_next_q, buf_valid_q;
  logic [IW-1:0]         buf_q;
  logic [6:0]            n_q;
  logic [6:0]            head_rd_q, next_rd_q;
  logic [IW-1:0]         tail_rd_q;
  logic                  res_valid_q;
  twtq_pkg::result_t     res_q;

  logic                  head_we, tail_we, next_we;
  logic [SW-1:0]         head_wa, head_ra;
  logic [6:0]            head_wd, next_wd;
  logic [IW-1:0]         next_wa, next_ra;
  logic [6:0]            e;
  logic                  take;
  logic                  emit;
  twtq_pkg::result_t     res_d;
  logic [IW-1:0]         cur_id;

  assign cur_id = cur_q.timer_id[IW-1:0];
  assign e      = from_next_q ? next_rd_q : head_rd_q;
  assign take   = (e < 7'(MAX_TIMERS)) && pending_q[e[IW-1:0]] && (n_q < 7'(MAX_TIMERS));
  assign pop_o  = (state_q == twtq_pkg::B_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      twtq_pkg::B_CLEAR: if (clr_q == SW'(WHEEL_SLOTS - 1)) state_d = twtq_pkg::B_IDLE;
      twtq_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          if (cmd_i.op == twtq_pkg::OP_TICK) begin
            state_d = twtq_pkg::B_TK_RD;
          end else if (cmd_i.op == twtq_pkg::OP_ADD && cmd_i.store
                       && !pending_q[cmd_i.timer_id[IW-1:0]]) begin
            state_d = twtq_pkg::B_ADD_RD;
          end
        end
      end
      twtq_pkg::B_ADD_RD: state_d = twtq_pkg::B_ADD_WR;
      twtq_pkg::B_ADD_WR: state_d = twtq_pkg::B_IDLE;
      twtq_pkg::B_TK_RD:  state_d = twtq_pkg::B_TK_EL;
      twtq_pkg::B_TK_EL: begin
        if (!take) state_d = (rem_q == '0) ? twtq_pkg::B_TK_END : twtq_pkg::B_TK_RD;
      end
      twtq_pkg::B_TK_END: state_d = twtq_pkg::B_IDLE;
      default:            state_d = twtq_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    head_we   = 1'b0;
    head_wa   = slot_q;
    head_wd   = twtq_pkg::EntryNil;
    head_ra   = slot_q;
    tail_we   = 1'b0;
    next_we   = 1'b0;
    next_wa   = cur_id;
    next_wd   = twtq_pkg::EntryNil;
    next_ra   = e[IW-1:0];
    pending_d = pending_q;
    emit      = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    case (state_q)
      twtq_pkg::B_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_q;
      end
      twtq_pkg::B_IDLE: begin
        if (!q_empty_i && cmd_i.op != twtq_pkg::OP_TICK && state_d == twtq_pkg::B_IDLE) begin
          emit          = 1'b1;
          res_d.status  = cmd_i.status;
          res_d.clamped = cmd_i.clamped;
        end
      end
      twtq_pkg::B_ADD_RD: begin
        head_ra = cur_q.slot[SW-1:0];
        next_we = 1'b1;
        pending_d[cur_id] = 1'b1;
      end
      twtq_pkg::B_ADD_WR: begin
        head_wa = cur_q.slot[SW-1:0];
        head_wd = {1'b0, cur_q.timer_id};
        if (head_rd_q == twtq_pkg::EntryNil) begin
          head_we = 1'b1;
        end else if ({1'b0, tail_rd_q} < 7'(MAX_TIMERS)) begin
          next_we = 1'b1;
          next_wa = tail_rd_q;
          next_wd = {1'b0, cur_q.timer_id};
        end
        tail_we       = 1'b1;
        emit          = 1'b1;
        res_d.clamped = cur_q.clamped;
      end
      twtq_pkg::B_TK_RD: begin
        head_we = 1'b1;
      end
      twtq_pkg::B_TK_EL: begin
        if (take) begin
          pending_d[e[IW-1:0]] = 1'b0;
          if (buf_valid_q) begin
            emit                = 1'b1;
            res_d.expired_valid = 1'b1;
            res_d.expired_id    = 6'(buf_q);
            res_d.last          = 1'b0;
          end
        end
      end
      twtq_pkg::B_TK_END: begin
        emit                = 1'b1;
        res_d.expired_valid = buf_valid_q;
        res_d.expired_id    = buf_valid_q ? 6'(buf_q) : 6'd0;
      end
      default: ;
    endcase
  end

  // memories: write and registered read
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
    if (tail_we) tail_mem[cur_q.slot[SW-1:0]] <= cur_id;
    tail_rd_q <= tail_mem[cur_q.slot[SW-1:0]];
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd_q <= next_mem[next_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= twtq_pkg::B_CLEAR;
      clr_q       <= '0;
      pending_q   <= '0;
      res_valid_q <= 1'b0;
      buf_valid_q <= 1'b0;
      from_next_q <= 1'b0;
      n_q         <= 7'd0;
      slot_q      <= '0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      res_valid_q <= emit;
      case (state_q)
        twtq_pkg::B_CLEAR: clr_q <= clr_q + SW'(1);
        twtq_pkg::B_IDLE: begin
          slot_q      <= cmd_i.slot[SW-1:0];
          rem_q       <= cmd_i.span_m1[SW-1:0];
          buf_valid_q <= 1'b0;
          n_q         <= 7'd0;
        end
        twtq_pkg::B_TK_RD: from_next_q <= 1'b0;
        twtq_pkg::B_TK_EL: begin
          if (take) begin
            from_next_q <= 1'b1;
            buf_valid_q <= 1'b1;
            n_q         <= n_q + 7'd1;
          end else if (rem_q != '0) begin
            slot_q <= (slot_q == SW'(WHEEL_SLOTS - 1)) ? '0 : slot_q + SW'(1);
            rem_q  <= rem_q - SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= cmd_i;
    if (state_q == twtq_pkg::B_TK_EL && take) buf_q <= e[IW-1:0];
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

### sv/timing_wheel_timer_queue.sv
// Top level of the millisecond timing wheel timer queue: front, command
// queue and back. Depends on twtq_pkg, twtq_front, twtq_queue, twtq_back.
//
// Usage: drive an item on in_i with start_i high; it is taken at a rising
// edge where busy_o is low. The front takes each item through capture, time
// compare and slot add, waiting while the queue is full; a two-entry queue
// lets it run ahead of the back. An add goes through a head/tail memory read,
// then a link write in the back and gives one result; a rejected add, an
// unstored add or an early tick gives one result in the cycle after it
// leaves the queue. A tick walks 1 to WHEEL_SLOTS slots, clearing each head
// and taking its expired timers, and ends with a final result; its length is
// set by the walk and the timers. Results appear on result_o for exactly one
// cycle with result_valid_o high and cannot be held off; last marks the
// final result of each item. After reset the back clears the slot head
// memory before it serves the first command; the queue still takes items.
module timing_wheel_timer_queue #(
  parameter int unsigned WHEEL_SLOTS = twtq_pkg::DefWheelSlots,
  parameter int unsigned MAX_TIMERS  = twtq_pkg::DefMaxTimers
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  twtq_pkg::item_t   in_i,
  output logic              result_valid_o,
  output twtq_pkg::result_t result_o
);

  logic                push;
  logic                pop;
  twtq_pkg::cmd_t      push_cmd;
  twtq_pkg::cmd_t      head_cmd;
  twtq_pkg::q_status_t q_status;

  // classify and place each item
  twtq_front #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .MAX_TIMERS  (MAX_TIMERS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .item_i   (in_i),
    .q_full_i (q_status.full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // hold commands so either side may stall alone
  twtq_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (q_status)
  );

  // carry out adds and slot drains against the wheel memories
  twtq_back #(
    .WHEEL_SLOTS (WHEEL_SLOTS),
    .MAX_TIMERS  (MAX_TIMERS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (head_cmd),
    .q_empty_i      (q_status.empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### sv/twtq_checker.sv
// Port-level checks for the timer queue, bound to the top level.
// Depends on twtq_pkg and timing_wheel_timer_queue.
module twtq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input twtq_pkg::result_t result_o
);

  // an accepted transaction keeps the front busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o low right after an accepted transaction");

  // a result with no expired timer always ends its transaction
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.expired_valid |-> result_o.last)
    else $error("non-final result without an expired timer");

  // expired timers carry a clean status
  a_expired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.expired_valid |->
      result_o.status == twtq_pkg::ST_OK && !result_o.clamped)
    else $error("expired result with status or clamp set");

  // clamp only on an add with a clean status, which ends its transaction
  a_clamp_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.clamped |->
      result_o.status == twtq_pkg::ST_OK && !result_o.expired_valid && result_o.last)
    else $error("clamp flag on a result that is not an accepted add");

endmodule

bind timing_wheel_timer_queue twtq_checker u_twtq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
